### hw/rtl/ipad_pkg.sv
// ----------------------------------------------------------------------------
// ipad_pkg
// Shared widths, constants and predictor tables for the interleaved
// PS-ADPCM frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipad_pkg;

  // Frame layout
  localparam int SAMPLES       = 28;
  localparam int IDX_W         = 5;
  localparam int BYTES_HALF_W  = 56;
  localparam int SAMPLE_BITS_W = 2 * BYTES_HALF_W;

  // Configuration and channel widths
  localparam int CFG_W  = 4;
  localparam int CMP_W  = 5;
  localparam int CHAN_W = 3;

  // Predictor arithmetic
  localparam int HIST_W = 32;
  localparam int COEF_W = 8;
  localparam int PROD_W = HIST_W + COEF_W;
  localparam int ACC_W  = 44;
  localparam int PCM_W  = 16;
  localparam int SF_W   = 5;

  localparam logic [3:0] MAX_SHIFT      = 4'd12;
  localparam logic [3:0] FALLBACK_SHIFT = 4'd9;
  localparam logic [SF_W-1:0] SCALE_BASE = 5'd20;
  localparam logic [3:0] AUX_MASK       = 4'hF;
  localparam logic [3:0] FILT_MAX       = 4'd4;

  localparam logic signed [HIST_W-1:0] PCM_MAX = 32'sd32767;
  localparam logic signed [HIST_W-1:0] PCM_MIN = -32'sd32768;

  // Input actions
  typedef enum logic {
    ACT_DECODE  = 1'b0,
    ACT_RESTART = 1'b1
  } action_t;

  // Filter pair table
  localparam logic signed [COEF_W-1:0] COEF_POS [5] = '{
    8'sd0, 8'sd60, 8'sd115, 8'sd98, 8'sd122
  };
  localparam logic signed [COEF_W-1:0] COEF_NEG [5] = '{
    8'sd0, 8'sd0, -8'sd52, -8'sd55, -8'sd60
  };

endpackage

`default_nettype wire

### hw/rtl/ipad_channels.sv
// ----------------------------------------------------------------------------
// ipad channels
// Valid/ready channel interfaces for frames in, samples out and the
// channel count register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipad_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [7:0]                           header_byte;
  logic [7:0]                           flag_byte;
  logic [ipad_pkg::BYTES_HALF_W-1:0]    sample_bytes_low;
  logic [ipad_pkg::BYTES_HALF_W-1:0]    sample_bytes_high;

  modport source (output valid, action, header_byte, flag_byte,
                  sample_bytes_low, sample_bytes_high, input ready);
  modport sink   (input valid, action, header_byte, flag_byte,
                  sample_bytes_low, sample_bytes_high, output ready);
endinterface

interface ipad_out_if;
  logic                               valid;
  logic                               ready;
  logic [ipad_pkg::CHAN_W-1:0]        channel;
  logic [ipad_pkg::IDX_W-1:0]         sample_index;
  logic signed [ipad_pkg::PCM_W-1:0]  pcm_sample;
  logic                               last_of_frame;

  modport source (output valid, channel, sample_index, pcm_sample, last_of_frame,
                  input ready);
  modport sink   (input valid, channel, sample_index, pcm_sample, last_of_frame,
                  output ready);
endinterface

interface ipad_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ipad_pkg::CFG_W-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/interleaved_ps_adpcm_decoder.sv
// ----------------------------------------------------------------------------
// interleaved_ps_adpcm_decoder
// Decodes 16-byte PS-ADPCM frames into 28 saturated 16-bit samples each,
// with per-channel predictor history for interleaved blocks.
// ----------------------------------------------------------------------------
// A decode frame is accepted while the block is idle and then runs 28 samples
// through a single predictor unit (two narrow coefficient multiplies and two
// adds), one sample per cycle while the sample output is being taken.
// Restart transactions and dropped auxiliary frames finish in the cycle they
// are accepted. The last sample sits in the output register while the next
// frame is already accepted. Channel history lives in flip-flops and is loaded
// at frame start and written back after the 28th sample. channel_count may be
// written at any time the block is idle.
`default_nettype none

module interleaved_ps_adpcm_decoder #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ipad_in_if.sink     in_chan,
  ipad_out_if.source  out_chan,
  ipad_cfg_if.sink    cfg_chan
);
  import ipad_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_CHANNELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;

  // Channel history and block tracking
  logic signed [HIST_W-1:0] hist_new_r [MAX_CHANNELS];
  logic signed [HIST_W-1:0] hist_old_r [MAX_CHANNELS];
  logic [CH_W-1:0]  pos_r;
  logic             await_r;
  logic [CFG_W-1:0] count_r;

  // Working registers for the frame in flight
  logic [CH_W-1:0]              ch_r;
  logic signed [COEF_W-1:0]     fp_r;
  logic signed [COEF_W-1:0]     fn_r;
  logic [SF_W-1:0]              sf_r;
  logic [SAMPLE_BITS_W-1:0]     nib_r;
  logic signed [HIST_W-1:0]     h1_r;
  logic signed [HIST_W-1:0]     h2_r;
  logic [IDX_W-1:0]             idx_r;

  // Output register
  logic                         out_valid_r;
  logic [CHAN_W-1:0]            out_ch_r;
  logic [IDX_W-1:0]             out_idx_r;
  logic signed [PCM_W-1:0]      out_pcm_r;
  logic                         out_last_r;

  // Effective channel count and channel for the offered frame
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cnt_eff;
  logic [CMP_W-1:0] pos_ext;
  logic [CH_W-1:0]  ch_sel;

  assign cnt_ext = {1'b0, count_r};
  assign pos_ext = CMP_W'(pos_r);

  always_comb begin
    if (cnt_ext == '0) begin
      cnt_eff = CMP_W'(1);
    end else if (cnt_ext > MAX_C) begin
      cnt_eff = MAX_C;
    end else begin
      cnt_eff = cnt_ext;
    end
    ch_sel = (pos_ext >= cnt_eff) ? '0 : pos_r;
  end

  // Decode header into filter pair and scale
  logic [3:0]      filt;
  logic [3:0]      shft;
  logic [2:0]      filt_idx;
  logic [SF_W-1:0] sf_sel;

  always_comb begin
    filt     = in_chan.header_byte[7:4];
    shft     = in_chan.header_byte[3:0];
    filt_idx = (filt > FILT_MAX) ? 3'd0 : filt[2:0];
    sf_sel   = SCALE_BASE - SF_W'((shft > MAX_SHIFT) ? FALLBACK_SHIFT : shft);
  end

  // Shared predictor unit: one sample per use
  logic signed [PROD_W-1:0] prod1;
  logic signed [PROD_W-1:0] prod2;
  logic signed [ACC_W-1:0]  scaled;
  logic signed [ACC_W-1:0]  acc;
  logic signed [HIST_W-1:0] hist;
  logic signed [PCM_W-1:0]  pcm;

  always_comb begin
    prod1  = h1_r * fp_r;
    prod2  = h2_r * fn_r;
    scaled = $signed({{(ACC_W-4){nib_r[3]}}, nib_r[3:0]}) <<< sf_r;
    acc    = ((ACC_W'(prod1) + ACC_W'(prod2)) <<< 2) + scaled;
    hist   = acc[HIST_W+7:8];
    if (hist > PCM_MAX) begin
      pcm = PCM_MAX[PCM_W-1:0];
    end else if (hist < PCM_MIN) begin
      pcm = PCM_MIN[PCM_W-1:0];
    end else begin
      pcm = hist[PCM_W-1:0];
    end
  end

  logic in_acc;
  logic step;
  logic [CMP_W-1:0] ch_next;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign step           = (state_r == ST_RUN) && (!out_valid_r || out_chan.ready);
  assign ch_next        = CMP_W'(ch_r) + CMP_W'(1);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.channel       = out_ch_r;
  assign out_chan.sample_index  = out_idx_r;
  assign out_chan.pcm_sample    = out_pcm_r;
  assign out_chan.last_of_frame = out_last_r;

  // Sequencer, history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      await_r     <= 1'b0;
      count_r     <= CFG_W'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        hist_new_r[i] <= '0;
        hist_old_r[i] <= '0;
      end
    end else begin
      // Register write
      if (cfg_chan.valid && cfg_chan.ready) begin
        count_r <= cfg_chan.data;
      end

      // Drop the held sample once taken
      if (out_valid_r && out_chan.ready && !step) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (action_t'(in_chan.action) == ACT_RESTART) begin
              pos_r   <= '0;
              await_r <= 1'b0;
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                hist_new_r[i] <= '0;
                hist_old_r[i] <= '0;
              end
            end else if (!(await_r && ((in_chan.flag_byte[3:0] & AUX_MASK) != '0))) begin
              await_r <= 1'b0;
              ch_r    <= ch_sel;
              fp_r    <= COEF_POS[filt_idx];
              fn_r    <= COEF_NEG[filt_idx];
              sf_r    <= sf_sel;
              nib_r   <= {in_chan.sample_bytes_high, in_chan.sample_bytes_low};
              h1_r    <= hist_new_r[ch_sel];
              h2_r    <= hist_old_r[ch_sel];
              idx_r   <= '0;
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (step) begin
            out_valid_r <= 1'b1;
            out_ch_r    <= CHAN_W'(ch_r);
            out_idx_r   <= idx_r;
            out_pcm_r   <= pcm;
            out_last_r  <= (idx_r == LAST_IDX);
            h2_r        <= h1_r;
            h1_r        <= hist;
            nib_r       <= nib_r >> 4;
            idx_r       <= idx_r + IDX_W'(1);
            // Write back history and advance block position
            if (idx_r == LAST_IDX) begin
              hist_new_r[ch_r] <= hist;
              hist_old_r[ch_r] <= h1_r;
              if (ch_next >= cnt_eff) begin
                pos_r   <= '0;
                await_r <= 1'b1;
              end else begin
                pos_r <= ch_next[CH_W-1:0];
              end
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interleaved PS-ADPCM decoder. It drives frame
// and channel-count transactions with random idling on both channels, decodes
// each accepted frame in a local model of the predictor and matches every
// output sample, field by field, against the oldest sample still due.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ipad_pkg::*;

  localparam int NUM_CH = 8;

  typedef struct packed {
    action_t     act;
    logic [7:0]  hdr;
    logic [7:0]  flag;
    logic [55:0] lo;
    logic [55:0] hi;
  } frame_t;

  typedef struct packed {
    frame_t             f;
    bit                 pinned;
    logic signed [15:0] pcm;
  } vec_t;

  typedef struct {
    logic [2:0]         channel;
    logic [4:0]         idx;
    logic signed [15:0] pcm;
    logic               last;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n;

  ipad_in_if  in_if ();
  ipad_out_if out_if ();
  ipad_cfg_if cfg_if ();

  interleaved_ps_adpcm_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always #4 clk = ~clk;

  // Decoder model state
  int          pair_pos [5] = '{0, 60, 115, 98, 122};
  int          pair_neg [5] = '{0, 0, -52, -55, -60};
  logic [31:0] hist_new [NUM_CH];
  logic [31:0] hist_old [NUM_CH];
  int unsigned blk_pos;
  bit          await_start;
  logic [3:0]  chan_cnt;

  sample_t samples_due [$];
  sample_t want;
  vec_t    directed [$];

  int src_idle_pct;
  int sink_idle_pct;
  int errors;
  int n_samples;
  int frames_decoded;
  int frames_dropped;
  int restarts;
  int cfg_writes;

  bit hold_req;
  bit hold_done;
  int hold_left;

  function automatic void clear_history();
    for (int i = 0; i < NUM_CH; i++) begin
      hist_new[i] = '0;
      hist_old[i] = '0;
    end
    blk_pos     = 0;
    await_start = 1'b0;
  endfunction

  // Decode one accepted frame and queue its 28 samples; a pinned value
  // replaces the computed sample where the result is known by hand.
  function automatic void decode_frame(frame_t f, bit pinned, logic signed [15:0] pin_pcm);
    int unsigned        cnt, ch, filt, shf;
    logic [111:0]       bits;
    logic [3:0]         nib;
    longint             snib, h1, h2, acc, fp, fn;
    logic [31:0]        hnext;
    logic signed [31:0] hs;
    logic signed [15:0] pcm;
    sample_t            smp;

    if (f.act == ACT_RESTART) begin
      clear_history();
      restarts++;
      return;
    end
    // Drop auxiliary frames between blocks
    if (await_start && (f.flag[3:0] != 4'h0)) begin
      frames_dropped++;
      return;
    end
    await_start = 1'b0;

    cnt = chan_cnt;
    if (cnt < 1) cnt = 1;
    if (cnt > NUM_CH) cnt = NUM_CH;
    ch = blk_pos;
    if (ch >= cnt) ch = 0;

    filt = f.hdr[7:4];
    if (filt > 4) filt = 0;
    shf = f.hdr[3:0];
    if (shf > 12) shf = 9;
    fp = pair_pos[filt];
    fn = pair_neg[filt];
    bits = {f.hi, f.lo};

    for (int s = 0; s < SAMPLES; s++) begin
      nib   = bits[4*s +: 4];
      snib  = longint'($signed(nib));
      h1    = longint'($signed(hist_new[ch]));
      h2    = longint'($signed(hist_old[ch]));
      acc   = snib * (longint'(1) << (20 - shf)) + (h1 * fp + h2 * fn) * 4;
      hnext = acc[39:8];
      hs    = $signed(hnext);
      if (hs > 32767) pcm = 16'sh7fff;
      else if (hs < -32768) pcm = 16'sh8000;
      else pcm = hs[15:0];

      smp.channel = ch[2:0];
      smp.idx     = s[4:0];
      smp.pcm     = pinned ? pin_pcm : pcm;
      smp.last    = (s == SAMPLES - 1);
      samples_due = {samples_due, smp};

      hist_old[ch] = hist_new[ch];
      hist_new[ch] = hnext;
    end

    // Advance block position
    ch++;
    if (ch >= cnt) begin
      blk_pos     = 0;
      await_start = 1'b1;
    end else begin
      blk_pos = ch;
    end
    frames_decoded++;
  endfunction

  function automatic void add_vec(action_t act, logic [7:0] hdr, logic [7:0] flag,
                                  logic [55:0] lo, logic [55:0] hi,
                                  bit pinned, logic signed [15:0] pcm);
    vec_t v;
    v.f      = '{act: act, hdr: hdr, flag: flag, lo: lo, hi: hi};
    v.pinned = pinned;
    v.pcm    = pcm;
    directed = {directed, v};
  endfunction

  function automatic frame_t make_frame(action_t act, logic [7:0] flag);
    frame_t f;
    f.act       = act;
    f.flag      = flag;
    f.hdr[7:4]  = ($urandom_range(99) < 80) ? 4'($urandom_range(4)) : 4'($urandom_range(15, 5));
    f.hdr[3:0]  = 4'($urandom_range(15));
    f.lo        = 56'({$urandom, $urandom});
    f.hi        = 56'({$urandom, $urandom});
    return f;
  endfunction

  // Offer one frame transaction; idle first at the sender's rate
  task automatic put_frame(frame_t f, bit pinned = 1'b0, logic signed [15:0] pin_pcm = '0);
    bit ok;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid             <= 1'b1;
    in_if.action            <= f.act;
    in_if.header_byte       <= f.hdr;
    in_if.flag_byte         <= f.flag;
    in_if.sample_bytes_low  <= f.lo;
    in_if.sample_bytes_high <= f.hi;
    do begin
      @(negedge clk);
      ok = in_if.ready;
      @(posedge clk);
    end while (!ok);
    decode_frame(f, pinned, pin_pcm);
  endtask

  // Hold the input and wait until every queued sample has drained
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(logic [3:0] val);
    bit ok;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= val;
    do begin
      @(negedge clk);
      ok = cfg_if.ready;
      @(posedge clk);
    end while (!ok);
    cfg_if.valid <= 1'b0;
    chan_cnt = val;
    cfg_writes++;
  endtask

  // Sample receiver: random stalls plus one long hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_if.ready <= 1'b0;
      hold_left    <= 400;
      hold_done    <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Check each sample transaction against the oldest one due
  always @(negedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      n_samples++;
      if (samples_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected sample: got ch %0d idx %0d pcm %0d last %0b", $time,
                 out_if.channel, out_if.sample_index, out_if.pcm_sample,
                 out_if.last_of_frame);
      end else begin
        want = samples_due.pop_front();
        if (out_if.channel !== want.channel || out_if.sample_index !== want.idx ||
            out_if.pcm_sample !== want.pcm || out_if.last_of_frame !== want.last) begin
          errors++;
          $display("%0t: sample mismatch: expected ch %0d idx %0d pcm %0d last %0b,",
                   $time, want.channel, want.idx, want.pcm, want.last);
          $display("    got ch %0d idx %0d pcm %0d last %0b",
                   out_if.channel, out_if.sample_index, out_if.pcm_sample,
                   out_if.last_of_frame);
        end
      end
    end
  end

  // Bound the run
  initial begin
    #(8 * 600000);
    $display("** interleaved_ps_adpcm_decoder: FAILED **");
    $finish;
  end

  initial begin
    static logic [3:0] counts [7] = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd2, 4'd5, 4'd1};
    int pick, n, target;

    // Drive every input to a known value
    rst_n                   <= 1'b0;
    in_if.valid             <= 1'b0;
    in_if.action            <= ACT_DECODE;
    in_if.header_byte       <= '0;
    in_if.flag_byte         <= '0;
    in_if.sample_bytes_low  <= '0;
    in_if.sample_bytes_high <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.data             <= '0;
    hold_req                <= 1'b0;
    clear_history();
    chan_cnt      = 4'd1;
    src_idle_pct  = 28;
    sink_idle_pct = 82;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames; filter zero makes each sample nibble * 2^(12 - shift)
    add_vec(ACT_DECODE,  8'h00, 8'h00, {7{8'h77}}, {7{8'h77}}, 1, 16'sd28672);
    add_vec(ACT_DECODE,  8'h00, 8'h01, {7{8'h77}}, {7{8'h77}}, 0, '0);
    add_vec(ACT_DECODE,  8'h00, 8'h10, {7{8'h88}}, {7{8'h88}}, 1, -16'sd32768);
    add_vec(ACT_DECODE,  8'hF0, 8'h00, {7{8'h77}}, {7{8'h77}}, 1, 16'sd28672);
    add_vec(ACT_DECODE,  8'h5C, 8'h00, {7{8'hFF}}, {7{8'hFF}}, 1, -16'sd1);
    add_vec(ACT_DECODE,  8'h0C, 8'h00, {7{8'h77}}, {7{8'h77}}, 1, 16'sd7);
    add_vec(ACT_DECODE,  8'h0F, 8'h00, {7{8'h77}}, {7{8'h77}}, 1, 16'sd56);
    add_vec(ACT_DECODE,  8'h0D, 8'h00, {7{8'h88}}, {7{8'h88}}, 1, -16'sd64);
    add_vec(ACT_DECODE,  8'h00, 8'h00, '0, '0, 1, 16'sd0);
    add_vec(ACT_DECODE,  8'h10, 8'h00, 56'h0123456789ABCD, 56'hFEDCBA98765432, 0, '0);
    add_vec(ACT_DECODE,  8'h24, 8'hA0, 56'h7F80F70887FF01, 56'h1E2D3C4B5A6978, 0, '0);
    add_vec(ACT_DECODE,  8'h38, 8'h00, 56'hC3A5965A3CE1D2, 56'h0F1E2D3C4B5A69, 0, '0);
    add_vec(ACT_DECODE,  8'h4B, 8'h00, 56'h55AA55AA55AA55, 56'hAA55AA55AA55AA, 0, '0);
    add_vec(ACT_DECODE,  8'h40, 8'h00, {7{8'h77}}, {7{8'h77}}, 0, '0);
    add_vec(ACT_DECODE,  8'h40, 8'h00, {7{8'h77}}, {7{8'h77}}, 0, '0);
    add_vec(ACT_DECODE,  8'h20, 8'h00, {7{8'h88}}, {7{8'h88}}, 0, '0);
    add_vec(ACT_DECODE,  8'h40, 8'hFF, {7{8'h11}}, {7{8'h11}}, 0, '0);
    add_vec(ACT_DECODE,  8'h40, 8'h0F, {7{8'h11}}, {7{8'h11}}, 0, '0);
    add_vec(ACT_RESTART, 8'h00, 8'h00, '0, '0, 0, '0);
    add_vec(ACT_DECODE,  8'h00, 8'h03, {7{8'h77}}, {7{8'h77}}, 1, 16'sd28672);
    add_vec(ACT_RESTART, 8'hFF, 8'hFF, {7{8'hFF}}, {7{8'hFF}}, 0, '0);
    add_vec(ACT_RESTART, 8'h00, 8'h00, '0, '0, 0, '0);
    add_vec(ACT_DECODE,  8'h3C, 8'h00, {7{8'hFF}}, {7{8'hFF}}, 0, '0);

    foreach (directed[i]) put_frame(directed[i].f, directed[i].pinned, directed[i].pcm);

    // Random phases, one channel-count setting each
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      if (p == 2) begin
        src_idle_pct  = 82;
        sink_idle_pct = 28;
      end else if (p == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req     <= 1'b1;
      end
      write_count(counts[p]);
      target = frames_decoded + 43;
      while (frames_decoded < target) begin
        pick = $urandom_range(99);
        if (pick < 6) begin
          put_frame(make_frame(ACT_RESTART, 8'($urandom)));
        end else if (pick < 14) begin
          put_frame(make_frame(ACT_DECODE, 8'($urandom)));
        end else begin
          // Well-formed block, then maybe a few auxiliary frames
          n = (chan_cnt == 0) ? 1 : ((chan_cnt > NUM_CH) ? NUM_CH : int'(chan_cnt));
          for (int k = 0; k < n; k++) begin
            put_frame(make_frame(ACT_DECODE,
                                 (k == 0) ? {4'($urandom_range(15)), 4'h0} : 8'($urandom)));
          end
          if ($urandom_range(99) < 40) begin
            repeat ($urandom_range(1, 3))
              put_frame(make_frame(ACT_DECODE,
                                   {4'($urandom_range(15)), 4'($urandom_range(15, 1))}));
          end
        end
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);

    $display("Decoded %0d frames (%0d samples checked), dropped %0d auxiliary frames,",
             frames_decoded, n_samples, frames_dropped);
    $display("applied %0d restarts over %0d channel-count writes; %0d mismatches.",
             restarts, cfg_writes, errors);
    if (errors == 0 && samples_due.size() == 0) begin
      $display("** interleaved_ps_adpcm_decoder: PASSED **");
    end else begin
      $display("** interleaved_ps_adpcm_decoder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
